// ===== src/polymac_pkg.sv =====
// Shared types and constants for the Poly1305 MAC engine.
// No dependencies; imported by poly1305_mac_engine_core.
`default_nettype none

package polymac_pkg;

  localparam int LIMB_W   = 26;               // radix-2^26 limb
  localparam int NLIMB    = 5;                // limbs in a 130-bit value
  localparam int ACC_W    = LIMB_W * NLIMB;   // 130
  localparam int H_W      = LIMB_W + 1;       // accumulator limb plus message limb
  localparam int R5_W     = LIMB_W + 3;       // 5 * r limb
  localparam int PROD_W   = H_W + R5_W;       // one partial product
  localparam int D_W      = 60;               // column sum of five products plus carries
  localparam int CARRY_W  = D_W - LIMB_W;
  localparam int BLK_BYTES = 16;
  localparam int BLK_W    = 8 * BLK_BYTES + 1; // block plus the appended one bit
  localparam int CNT_W    = 4;                // pending bytes 0..15
  localparam int ABS_N_W  = 5;                // absorbed block length 1..16
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 2;
  localparam int TAG_W    = 128;

  localparam logic [CFG_W-1:0] R_LOW_CLAMP  = 64'h0fff_fffc_0fff_ffff;
  localparam logic [CFG_W-1:0] R_HIGH_CLAMP = 64'h0fff_fffc_0fff_fffc;

  localparam logic [CFG_IDX_W-1:0] CFG_R_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_R_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_S_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_S_HIGH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,   // take byte transfers
    ST_LOAD,   // form the block, add it to the accumulator, latch clamped r
    ST_MUL,    // 25 limb products through the shared multiplier
    ST_CARRY,  // three carry passes, one limb per cycle
    ST_FINAL,  // conditional subtract of the prime
    ST_TAG     // add s and hand the tag to the output register
  } state_t;

endpackage

`default_nettype wire

// ===== src/poly1305_mac_engine_core.sv =====
// Poly1305 MAC engine top level: byte stream in, 128-bit tag out.
// Depends on polymac_pkg for limb widths, register indexes and the state type.
`default_nettype none

// Message bytes arrive one per transfer on the in_ stream and are taken one
// per cycle while the engine is idle and the 16-byte block buffer fills. When
// a block is full, or when a transfer with in_tlast closes a message with a
// partial block pending, the block is absorbed and in_tready drops while the
// block is formed and added into the accumulator, a single shared 27x29-bit
// multiplier produces the 25 limb products of the radix-2^26 multiply,
// carries propagate one limb per cycle, and the final subtract of 2^130-5
// is made. A closing transfer adds a tag step in which s is added and the
// tag is loaded into the output register once that register is free; the
// tag then waits there on the out_ stream while the next message's bytes
// are already taken. A transfer with in_tuser low and in_tlast high closes a
// message without a byte (empty messages give tag = s). Key registers are to
// be written through cfg_ only while the engine is idle; the user is bound to
// this and the block itself does not enforce it. r is clamped internally.
module poly1305_mac_engine_core (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // configuration write port
  input  wire                                 cfg_we,
  input  wire  [polymac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [polymac_pkg::CFG_W-1:0]       cfg_wdata,
  // byte stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire  [7:0]                          in_tdata,  // [7:0] data_byte
  input  wire                                 in_tuser,  // [0] has_byte
  input  wire                                 in_tlast,  // last
  // tag stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  output logic [polymac_pkg::TAG_W-1:0]       out_tdata  // [63:0] tag_low, [127:64] tag_high
);

  import polymac_pkg::*;

  // control state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  last_pend_r, last_pend_nxt;
  logic [2:0]            i_r, i_nxt;
  logic [2:0]            j_r, j_nxt;
  logic                  issue_done_r, issue_done_nxt;
  logic                  prod_v_r, prod_v_nxt;
  logic                  prod_last_r, prod_last_nxt;
  logic                  prod_col_last_r, prod_col_last_nxt;
  logic [2:0]            k_r, k_nxt;
  logic [1:0]            pass_r, pass_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;

  // key registers
  logic [CFG_W-1:0]      r_low_r, r_low_nxt;
  logic [CFG_W-1:0]      r_high_r, r_high_nxt;
  logic [CFG_W-1:0]      s_low_r, s_low_nxt;
  logic [CFG_W-1:0]      s_high_r, s_high_nxt;

  // datapath
  logic [7:0]            blk_buf_r [BLK_BYTES];
  logic [ABS_N_W-1:0]    abs_n_r, abs_n_nxt;
  logic [H_W-1:0]        h_r [NLIMB];
  logic [H_W-1:0]        h_nxt [NLIMB];
  logic [LIMB_W-1:0]     r_lat_r [NLIMB];
  logic [LIMB_W-1:0]     r_lat_nxt [NLIMB];
  logic [D_W-1:0]        d_r [NLIMB];
  logic [D_W-1:0]        d_nxt [NLIMB];
  logic [D_W-1:0]        dacc_r, dacc_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;

  // helpers
  logic                  in_fire;
  logic [ABS_N_W-1:0]    cnt_new;
  logic [BLK_W-1:0]      blk;
  logic [127:0]          r_clamp;
  logic [2:0]            ridx;
  logic [LIMB_W-1:0]     r_base;
  logic [R5_W-1:0]       r_sel;
  logic [D_W-1:0]        col_sum;
  logic [CARRY_W-1:0]    carry;
  logic [D_W-1:0]        carry_add;
  logic [ACC_W-1:0]      v;
  logic [ACC_W:0]        g;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = tag_r;
  assign cnt_new    = ABS_N_W'(cnt_r) + ABS_N_W'(in_tuser);

  // block assembly: bytes below the length, then the 0x01 marker, then zeros
  always_comb begin
    for (int b = 0; b < BLK_BYTES; b++) begin
      if (ABS_N_W'(b) < abs_n_r) begin
        blk[8*b +: 8] = blk_buf_r[b];
      end else if (ABS_N_W'(b) == abs_n_r) begin
        blk[8*b +: 8] = 8'h01;
      end else begin
        blk[8*b +: 8] = 8'h00;
      end
    end
    blk[BLK_W-1] = (abs_n_r == ABS_N_W'(BLK_BYTES));
  end

  assign r_clamp = {r_high_r & R_HIGH_CLAMP, r_low_r & R_LOW_CLAMP};

  // operand select for the shared multiplier: column j takes h[i] * r[j-i],
  // with the wrapped terms scaled by 5 (2^130 = 5 mod p)
  always_comb begin
    if (j_r >= i_r) begin
      ridx = j_r - i_r;
    end else begin
      ridx = j_r + 3'd5 - i_r;
    end
    r_base = r_lat_r[ridx];
    if (i_r > j_r) begin
      r_sel = R5_W'({r_base, 2'b00}) + R5_W'(r_base);
    end else begin
      r_sel = R5_W'(r_base);
    end
    prod_nxt = PROD_W'(h_r[i_r]) * PROD_W'(r_sel);
  end

  assign col_sum   = dacc_r + D_W'(prod_r);
  assign carry     = d_r[0][D_W-1:LIMB_W];
  assign carry_add = (k_r == 3'd4) ? (D_W'({carry, 2'b00}) + D_W'(carry)) : D_W'(carry);

  always_comb begin
    for (int n = 0; n < NLIMB; n++) begin
      v[LIMB_W*n +: LIMB_W] = d_r[n][LIMB_W-1:0];
    end
    g = {1'b0, v} + (ACC_W+1)'(5);
  end

  // next state and datapath
  always_comb begin
    state_nxt         = state_r;
    cnt_nxt           = cnt_r;
    last_pend_nxt     = last_pend_r;
    i_nxt             = i_r;
    j_nxt             = j_r;
    issue_done_nxt    = issue_done_r;
    prod_v_nxt        = 1'b0;
    prod_last_nxt     = 1'b0;
    prod_col_last_nxt = 1'b0;
    k_nxt             = k_r;
    pass_nxt          = pass_r;
    acc_nxt           = acc_r;
    abs_n_nxt         = abs_n_r;
    dacc_nxt          = dacc_r;
    tag_nxt           = tag_r;
    r_low_nxt         = r_low_r;
    r_high_nxt        = r_high_r;
    s_low_nxt         = s_low_r;
    s_high_nxt        = s_high_r;
    for (int n = 0; n < NLIMB; n++) begin
      h_nxt[n]     = h_r[n];
      r_lat_nxt[n] = r_lat_r[n];
      d_nxt[n]     = d_r[n];
    end

    // drop the tag once taken
    out_valid_nxt = out_valid_r && !out_tready;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_R_LOW:  r_low_nxt  = cfg_wdata;
        CFG_R_HIGH: r_high_nxt = cfg_wdata;
        CFG_S_LOW:  s_low_nxt  = cfg_wdata;
        CFG_S_HIGH: s_high_nxt = cfg_wdata;
        default:    ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser && (cnt_r == CNT_W'(BLK_BYTES - 1))) begin
            // full block: absorb, then close if this was the last byte
            abs_n_nxt     = ABS_N_W'(BLK_BYTES);
            cnt_nxt       = '0;
            last_pend_nxt = in_tlast;
            state_nxt     = ST_LOAD;
          end else if (in_tlast) begin
            cnt_nxt = '0;
            if (cnt_new != '0) begin
              abs_n_nxt     = cnt_new;
              last_pend_nxt = 1'b1;
              state_nxt     = ST_LOAD;
            end else begin
              state_nxt = ST_TAG;
            end
          end else begin
            cnt_nxt = cnt_new[CNT_W-1:0];
          end
        end
      end

      ST_LOAD: begin
        for (int n = 0; n < NLIMB - 1; n++) begin
          h_nxt[n]     = H_W'(acc_r[LIMB_W*n +: LIMB_W]) + H_W'(blk[LIMB_W*n +: LIMB_W]);
          r_lat_nxt[n] = r_clamp[LIMB_W*n +: LIMB_W];
        end
        h_nxt[NLIMB-1]     = H_W'(acc_r[ACC_W-1:LIMB_W*(NLIMB-1)])
                           + H_W'(blk[BLK_W-1:LIMB_W*(NLIMB-1)]);
        r_lat_nxt[NLIMB-1] = LIMB_W'(r_clamp[127:LIMB_W*(NLIMB-1)]);
        i_nxt          = '0;
        j_nxt          = '0;
        issue_done_nxt = 1'b0;
        dacc_nxt       = '0;
        state_nxt      = ST_MUL;
      end

      ST_MUL: begin
        // issue one product per cycle
        if (!issue_done_r) begin
          prod_v_nxt        = 1'b1;
          prod_last_nxt     = (i_r == 3'd4);
          prod_col_last_nxt = (i_r == 3'd4) && (j_r == 3'd4);
          if (i_r == 3'd4) begin
            i_nxt = '0;
            if (j_r == 3'd4) begin
              issue_done_nxt = 1'b1;
            end else begin
              j_nxt = j_r + 3'd1;
            end
          end else begin
            i_nxt = i_r + 3'd1;
          end
        end
        // accumulate the registered product; shift a finished column in
        if (prod_v_r) begin
          if (prod_last_r) begin
            for (int n = 0; n < NLIMB - 1; n++) begin
              d_nxt[n] = d_r[n+1];
            end
            d_nxt[NLIMB-1] = col_sum;
            dacc_nxt       = '0;
            if (prod_col_last_r) begin
              k_nxt     = '0;
              pass_nxt  = '0;
              state_nxt = ST_CARRY;
            end
          end else begin
            dacc_nxt = col_sum;
          end
        end
      end

      ST_CARRY: begin
        // rotate the limbs so the working limb is always at the head
        d_nxt[0] = d_r[1] + carry_add;
        d_nxt[1] = d_r[2];
        d_nxt[2] = d_r[3];
        d_nxt[3] = d_r[4];
        d_nxt[4] = D_W'(d_r[0][LIMB_W-1:0]);
        if (k_r == 3'd4) begin
          k_nxt = '0;
          if (pass_r == 2'd2) begin
            state_nxt = ST_FINAL;
          end else begin
            pass_nxt = pass_r + 2'd1;
          end
        end else begin
          k_nxt = k_r + 3'd1;
        end
      end

      ST_FINAL: begin
        acc_nxt = g[ACC_W] ? g[ACC_W-1:0] : v;
        state_nxt = last_pend_r ? ST_TAG : ST_IDLE;
      end

      ST_TAG: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          tag_nxt       = acc_r[TAG_W-1:0] + {s_high_r, s_low_r};
          out_valid_nxt = 1'b1;
          acc_nxt       = '0;
          last_pend_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      last_pend_r     <= 1'b0;
      i_r             <= '0;
      j_r             <= '0;
      issue_done_r    <= 1'b0;
      prod_v_r        <= 1'b0;
      prod_last_r     <= 1'b0;
      prod_col_last_r <= 1'b0;
      k_r             <= '0;
      pass_r          <= '0;
      out_valid_r     <= 1'b0;
      acc_r           <= '0;
      r_low_r         <= '0;
      r_high_r        <= '0;
      s_low_r         <= '0;
      s_high_r        <= '0;
    end else begin
      state_r         <= state_nxt;
      cnt_r           <= cnt_nxt;
      last_pend_r     <= last_pend_nxt;
      i_r             <= i_nxt;
      j_r             <= j_nxt;
      issue_done_r    <= issue_done_nxt;
      prod_v_r        <= prod_v_nxt;
      prod_last_r     <= prod_last_nxt;
      prod_col_last_r <= prod_col_last_nxt;
      k_r             <= k_nxt;
      pass_r          <= pass_nxt;
      out_valid_r     <= out_valid_nxt;
      acc_r           <= acc_nxt;
      r_low_r         <= r_low_nxt;
      r_high_r        <= r_high_nxt;
      s_low_r         <= s_low_nxt;
      s_high_r        <= s_high_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_fire && in_tuser) begin
      blk_buf_r[cnt_r] <= in_tdata;
    end
    abs_n_r <= abs_n_nxt;
    dacc_r  <= dacc_nxt;
    prod_r  <= prod_nxt;
    tag_r   <= tag_nxt;
    for (int n = 0; n < NLIMB; n++) begin
      h_r[n]     <= h_nxt[n];
      r_lat_r[n] <= r_lat_nxt[n];
      d_r[n]     <= d_nxt[n];
    end
  end

  // a sixteenth byte always starts an absorb
  a_full_block_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser && (cnt_r == CNT_W'(BLK_BYTES - 1))) |=> (state_r == ST_LOAD))
    else $error("full block did not start an absorb");

  // products are only in flight during the multiply phase
  a_prod_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r |-> (state_r == ST_MUL))
    else $error("product valid outside multiply phase");

  // column accumulator is empty once all columns are shifted out
  a_dacc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CARRY) |-> (dacc_r == '0))
    else $error("column accumulator not cleared");

  // no bytes are pending while a block is being reduced
  a_cnt_clear_final: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL) |-> (cnt_r == '0))
    else $error("byte count not cleared during absorb");

  // a tag only appears from the tag state
  a_tag_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_TAG))
    else $error("tag valid raised outside tag state");

endmodule

`default_nettype wire

// ===== tb/sv/tb_poly1305_mac_engine_core.sv =====
// Self-checking testbench for poly1305_mac_engine_core: byte stream in, tag stream out.
// Depends on polymac_pkg for register indexes, clamp masks and widths.
// Tags are predicted with plain wide arithmetic modulo 2^130-5 and checked in order.
`default_nettype none

module tb_poly1305_mac_engine_core;
  import polymac_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 9;
  // covers an absorb and the tag step; leave margin on top
  localparam int DRAIN_CYCLES  = 60;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 285;
  localparam int LONG_HOLD     = 700;
  localparam int MAX_REPORTS   = 40;
  localparam int WIDE_W        = 2 * ACC_W;
  localparam logic [ACC_W:0] PRIME = (131'd1 << ACC_W) - 131'd5;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } msg_item_t;

  // receiver back-pressure patterns
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_R_LOW;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  wire                  in_tready;
  logic [7:0]           in_tdata   = '0;   // [7:0] data_byte
  logic                 in_tuser   = 1'b0; // [0] has_byte
  logic                 in_tlast   = 1'b0; // last
  wire                  out_tvalid;
  logic                 out_tready = 1'b0;
  wire  [TAG_W-1:0]     out_tdata;         // [63:0] tag_low, [127:64] tag_high

  // key registers as the engine should hold them
  logic [CFG_W-1:0] key_copy [0:3] = '{default: '0};

  // predicted engine state
  logic [ACC_W-1:0] acc_st  = '0;
  logic [127:0]     blk_st  = '0;
  int unsigned      blk_cnt = 0;

  msg_item_t        msg_items [$];
  logic [TAG_W-1:0] tags_due  [$];

  int unsigned items_queued = 0;
  int unsigned stim_items   = 0;
  int unsigned key_settings = 0;
  int unsigned items_taken  = 0;
  int unsigned bytes_taken  = 0;
  int unsigned tags_checked = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;

  poly1305_mac_engine_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // Tag prediction
  // ---------------------------------------------------------------------------

  // (h * r) mod 2^130-5: fold the bits above 130 back in times five, then
  // drop one prime if the folded value still reaches it.
  function automatic logic [ACC_W-1:0] poly_mulmod(input logic [ACC_W:0] h,
                                                   input logic [127:0] r);
    logic [WIDE_W-1:0] x;
    x = WIDE_W'(h);
    x = x * r;
    while (x[WIDE_W-1:ACC_W] != '0)
      x = x[ACC_W-1:0] + x[WIDE_W-1:ACC_W] * 3'd5;
    if (x >= PRIME)
      x = x - PRIME;
    return x[ACC_W-1:0];
  endfunction

  // Add a block (0x01 already appended) and multiply by the clamped r.
  task automatic poly_absorb(input logic [ACC_W-1:0] blk);
    logic [127:0] r_clamped;
    r_clamped = {key_copy[CFG_R_HIGH] & R_HIGH_CLAMP, key_copy[CFG_R_LOW] & R_LOW_CLAMP};
    acc_st = poly_mulmod({1'b0, acc_st} + blk, r_clamped);
  endtask

  // Advance the predicted state by one accepted transfer; queue a tag on close.
  task automatic predict_transfer(input logic [7:0] data, input logic has_byte,
                                  input logic last);
    logic [ACC_W-1:0] blk;
    logic [TAG_W-1:0] s_key;
    if (has_byte) begin
      blk_st[8*blk_cnt +: 8] = data;
      blk_cnt++;
      if (blk_cnt == BLK_BYTES) begin
        poly_absorb({2'b01, blk_st});
        blk_st  = '0;
        blk_cnt = 0;
      end
    end
    if (last) begin
      // a partial block gets its 0x01 right above its last byte
      if (blk_cnt != 0) begin
        blk = {2'b00, blk_st};
        blk[8*blk_cnt] = 1'b1;
        poly_absorb(blk);
        blk_st  = '0;
        blk_cnt = 0;
      end
      s_key = {key_copy[CFG_S_HIGH], key_copy[CFG_S_LOW]};
      tags_due.push_back(acc_st[TAG_W-1:0] + s_key);
      acc_st = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: pops pending items, sends them in bursts with random gaps
  // ---------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    msg_item_t item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      // previous transfer (if any) went through: offer the next one or idle
      if (gap_left != 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (msg_items.size() != 0) begin
        item = msg_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= item.data;
        in_tuser  <= item.has_byte;
        in_tlast  <= item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 32);
          // mostly short gaps, three bursts in ten back to back, a few long pauses
          if ($urandom_range(0, 9) == 0)
            gap_left <= $urandom_range(10, 40);
          else if ($urandom_range(0, 2) == 0)
            gap_left <= 0;
          else
            gap_left <= $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: own stall pattern, plus a long hold-off at a few tag counts so
  // the engine parks a tag in its output register and then stalls its input
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode      = RX_OPEN;
  int unsigned rx_mode_left = 0;
  int unsigned rx_tick      = 0;
  int unsigned hold_left    = 0;
  int unsigned hold_mark    = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick <= rx_tick + 1;
      if (hold_left != 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (tags_checked != hold_mark &&
                   (tags_checked == 12 || tags_checked == 60 || tags_checked == 110)) begin
        hold_mark  <= tags_checked;
        hold_left  <= LONG_HOLD;
        out_tready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      <= rx_mode_t'($urandom_range(0, 2));
          rx_mode_left <= $urandom_range(50, 300);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          RX_OPEN: begin
            out_tready <= 1'b1;
          end
          RX_COIN: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_tready <= (rx_tick % 8 == 0);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check tags first, then predict from the accepted input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [TAG_W-1:0] tag_exp;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        tags_checked <= tags_checked + 1;
        if (tags_due.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: tag with none expected, actual %h", $time, out_tdata);
        end else begin
          tag_exp = tags_due.pop_front();
          if (out_tdata[63:0] !== tag_exp[63:0]) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: tag_low mismatch, expected %h actual %h",
                       $time, tag_exp[63:0], out_tdata[63:0]);
          end
          if (out_tdata[127:64] !== tag_exp[127:64]) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: tag_high mismatch, expected %h actual %h",
                       $time, tag_exp[127:64], out_tdata[127:64]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_transfer(in_tdata, in_tuser, in_tlast);
        items_taken <= items_taken + 1;
        if (in_tuser)
          bytes_taken <= bytes_taken + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d tags still expected, %0d of %0d items taken",
               $time, tags_due.size(), items_taken, items_queued);
      $display("tb_poly1305_mac_engine_core NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [7:0] data, input logic has_byte, input logic last);
    msg_items.push_back({data, has_byte, last});
    items_queued++;
  endtask

  // Wait until every item is taken and every tag is back, then let the
  // engine finish any absorb that produces no tag.
  task automatic settle();
    do @(negedge clk);
    while (items_taken != items_queued || tags_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    key_copy[idx] = val;
  endtask

  task automatic set_keys(input logic [CFG_W-1:0] r_lo, input logic [CFG_W-1:0] r_hi,
                          input logic [CFG_W-1:0] s_lo, input logic [CFG_W-1:0] s_hi);
    write_key(CFG_R_LOW, r_lo);
    write_key(CFG_R_HIGH, r_hi);
    write_key(CFG_S_LOW, s_lo);
    write_key(CFG_S_HIGH, s_hi);
    @(posedge clk);
    cfg_we <= 1'b0;
    key_settings++;
    @(negedge clk);
  endtask

  // zero, all ones, or random
  function automatic logic [CFG_W-1:0] pick_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One message: mostly short, some exact block multiples, a few long or empty.
  // Idle transfers (no byte, no close) are sprinkled in and do not count.
  task automatic add_message();
    int unsigned len;
    int unsigned pick;
    logic        close_on_byte;
    pick = $urandom_range(0, 99);
    if (pick < 5)
      len = 0;
    else if (pick < 15)
      len = 16 * $urandom_range(1, 3);
    else if (pick < 90)
      len = $urandom_range(1, 20);
    else
      len = $urandom_range(21, 70);
    close_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0)
        push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
      stim_items++;
    end
    if (!close_on_byte) begin
      push_item(8'($urandom), 1'b0, 1'b1);
      stim_items++;
    end
  endtask

  initial begin
    int unsigned phase_start;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset keys (all zero): empty message, then one zero byte closing.
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    settle();

    // All-ones keys: empty message gives s, byte with close, byte then an
    // idle transfer then a close without byte, and a full block whose last
    // byte carries the close.
    set_keys('1, '1, '1, '1);
    push_item(8'hff, 1'b0, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b0);
    push_item(8'ha5, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    for (int i = 0; i < BLK_BYTES; i++)
      push_item(8'hff, 1'b1, i == BLK_BYTES - 1);
    settle();

    // Random messages under several key settings; the sender pauses for
    // every tag before each new setting.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_keys(pick_key(), pick_key(), pick_key(), pick_key());
      phase_start = stim_items;
      while (stim_items - phase_start < PHASE_ITEMS)
        add_message();
      settle();
    end

    $display("covered %0d transfers (%0d message bytes) and %0d tags over %0d key settings",
             items_taken, bytes_taken, tags_checked, key_settings + 1);
    $display("including long receiver hold-offs and idle transfers between bytes");
    if (fail_count == 0) begin
      $display("tb_poly1305_mac_engine_core OK");
    end else begin
      $display("tb_poly1305_mac_engine_core NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
